// File: hw/rtl/cls_pkg.sv
package cls_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed port widths.
	localparam int FUNC_W    = 3;
	localparam int ENTRY_W   = 32;
	localparam int INDEX_W   = 9;
	localparam int COUNT_W   = 7;
	localparam int POS_W     = 6;

	// Signed width for positions, bounds and the count inside the cell row.
	localparam int CMD_IDX_W = 10;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_RANGE  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MARK   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LIST   = 3'd4;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_APPEND,
		OP_MARK_SET,
		OP_MARK_ADD,
		OP_CLEAR,
		OP_STEP,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                     op;
		logic signed [CMD_IDX_W-1:0] lo;
		logic signed [CMD_IDX_W-1:0] hi;
		logic signed [CMD_IDX_W-1:0] count;
	} cell_cmd_t;

endpackage

// File: hw/rtl/cls_cell.sv
module cls_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = cls_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cls_pkg::cell_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] wrap_data,
	input  logic [DATA_WIDTH-1:0] up_data,
	input  logic                  up_mark,
	input  logic [DATA_WIDTH-1:0] down_data,
	input  logic                  down_mark,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  mark,
	output logic                  top_hole
);
	import cls_pkg::*;

	localparam logic signed [CMD_IDX_W-1:0] POS    = CMD_IDX_W'(IDX);
	localparam logic signed [CMD_IDX_W-1:0] POS_UP = CMD_IDX_W'(IDX + 1);

	logic [DATA_WIDTH-1:0] data_q, data_d;
	logic                  mark_q, mark_d;
	logic                  in_live, up_live, is_top, in_range, hit;
	logic                  take_up, take_down;

	assign in_live  = POS < cmd.count;
	assign up_live  = POS_UP < cmd.count;
	assign is_top   = POS_UP == cmd.count;
	assign in_range = (POS >= cmd.lo) && (POS <= cmd.hi) && in_live;
	assign hit      = (POS == cmd.lo) && in_live;

	// A marked cell swaps with an unmarked upper neighbor, so holes rise to
	// the top of the live region while the kept words keep their order.
	assign take_up   = mark_q && !up_mark && up_live;
	assign take_down = down_mark && !mark_q && in_live;

	always_comb begin
		data_d = data_q;
		mark_d = mark_q;
		case (cmd.op)
			OP_HOLD: begin
			end
			OP_APPEND: begin
				mark_d = 1'b0;
				if (POS == cmd.count) begin
					data_d = din;
				end
			end
			OP_MARK_SET: begin
				mark_d = in_range;
			end
			OP_MARK_ADD: begin
				mark_d = mark_q | hit;
			end
			OP_CLEAR: begin
				mark_d = 1'b0;
			end
			OP_STEP: begin
				if (take_up) begin
					data_d = up_data;
					mark_d = 1'b0;
				end else if (take_down) begin
					data_d = down_data;
					mark_d = 1'b1;
				end else if (mark_q && is_top) begin
					mark_d = 1'b0;
				end
			end
			OP_ROTATE: begin
				data_d = is_top ? wrap_data : up_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else begin
			mark_q <= mark_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data     = data_q;
	assign mark     = mark_q;
	assign top_hole = mark_q && is_top;

endmodule

// File: hw/rtl/compacting_list_store.sv
// Ordered list of up to DEPTH words, kept packed from position 0.
// Input channel (in_valid/in_stall) takes one word per operation: append,
// remove one, remove a clipped range, mark an index of a set-removal run,
// or list all. Output channel (out_valid/out_stall) returns one result word
// per operation, or one word per entry for a list of a non-empty list.
// The list lives in a row of DEPTH cells; each cell holds one entry and its
// removal mark and exchanges with its neighbors in compaction and listing.
// Append, refused, unused-code or non-final mark operations load their
// result word from the response state, once the output register is free.
// Removals run the cell row in compaction steps, one per cycle, while the
// holes rise to the top and drop off there, after which the result word
// is loaded. Listing rotates the row by one cell per delivered word, so it
// streams one word per cycle while the receiver takes them.
// One operation is in flight at a time: in_stall is high from acceptance
// until its last result word is loaded into the output register.
// A stalled output word holds; compaction continues underneath it.
// Reset clears the count, the marks and the output valid flag; entry words
// are not cleared, only positions below the count are ever read.
module compacting_list_store #(
	parameter int DEPTH      = cls_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cls_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cls_pkg::FUNC_W-1:0]          func,
	input  logic [cls_pkg::ENTRY_W-1:0]         entry_data,
	input  logic signed [cls_pkg::INDEX_W-1:0]  first_index,
	input  logic signed [cls_pkg::INDEX_W-1:0]  end_index,
	input  logic                                set_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                ok,
	output logic [cls_pkg::COUNT_W-1:0]         entry_count,
	output logic [cls_pkg::POS_W-1:0]           position,
	output logic [cls_pkg::ENTRY_W-1:0]         entry_value,
	output logic                                has_entry,
	output logic                                last
);
	import cls_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int XW = (DATA_WIDTH > ENTRY_W) ? DATA_WIDTH : ENTRY_W;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_COMPACT = 4'b0010,
		ST_RESP    = 4'b0100,
		ST_LIST    = 4'b1000
	} state_t;

	state_t                       state_q, state_d;
	logic [CW-1:0]                count_q, count_d;
	logic [IW-1:0]                idx_q, idx_d;
	logic                         any_marked_q, any_d;
	logic                         res_ok_q, res_ok_d;

	logic                         out_valid_q;
	logic                         ok_q;
	logic [COUNT_W-1:0]           entry_count_q;
	logic [POS_W-1:0]             position_q;
	logic [ENTRY_W-1:0]           entry_value_q;
	logic                         has_entry_q;
	logic                         last_q;

	logic                         load, ld_ok, ld_has, ld_last;
	logic                         out_free, list_last, a_ok, range_ok, fits;
	logic signed [CMD_IDX_W-1:0] a_x, b_x, cnt_x;
	cell_cmd_t                    cmd;

	logic [DATA_WIDTH-1:0]        data_v [DEPTH+2];
	logic [DEPTH+1:0]             mark_v;
	logic [DEPTH-1:0]             hole_v;
	logic                         mark_any, hole_any;
	logic [XW-1:0]                din_x, dout_x;

	assign din_x  = XW'(entry_data);
	assign dout_x = XW'(data_v[1]);

	// Cell k sits at slot k+1; the outer slots are tied off.
	assign data_v[0]         = '0;
	assign data_v[DEPTH+1]   = '0;
	assign mark_v[0]         = 1'b0;
	assign mark_v[DEPTH+1]   = 1'b0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			cls_cell #(
				.IDX        (g),
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.din       (din_x[DATA_WIDTH-1:0]),
				.wrap_data (data_v[1]),
				.up_data   (data_v[g+2]),
				.up_mark   (mark_v[g+2]),
				.down_data (data_v[g]),
				.down_mark (mark_v[g]),
				.data      (data_v[g+1]),
				.mark      (mark_v[g+1]),
				.top_hole  (hole_v[g])
			);
		end
	endgenerate

	assign mark_any = |mark_v[DEPTH:1];
	assign hole_any = |hole_v;

	assign a_x   = CMD_IDX_W'(first_index);
	assign b_x   = CMD_IDX_W'(end_index);
	assign cnt_x = $signed(CMD_IDX_W'(count_q));

	assign a_ok     = !a_x[CMD_IDX_W-1] && (a_x < cnt_x);
	assign range_ok = (a_x <= b_x) && !b_x[CMD_IDX_W-1] && (a_x < cnt_x);
	assign fits     = count_q < CW'(DEPTH);

	assign out_free  = !out_valid_q || !out_stall;
	assign list_last = CW'(idx_q) == (count_q - CW'(1));
	assign in_stall  = state_q != ST_IDLE;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		any_d     = any_marked_q;
		res_ok_d  = res_ok_q;
		load      = 1'b0;
		ld_ok     = res_ok_q;
		ld_has    = 1'b0;
		ld_last   = 1'b1;
		cmd.op    = OP_HOLD;
		cmd.lo    = a_x;
		cmd.hi    = b_x;
		cmd.count = cnt_x;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_APPEND: begin
							any_d    = 1'b0;
							cmd.op   = OP_APPEND;
							res_ok_d = fits;
							if (fits) begin
								count_d = count_q + CW'(1);
							end
							state_d = ST_RESP;
						end
						FUNC_REMOVE: begin
							any_d  = 1'b0;
							cmd.hi = a_x;
							if (a_ok) begin
								cmd.op   = OP_MARK_SET;
								res_ok_d = 1'b1;
								state_d  = ST_COMPACT;
							end else begin
								cmd.op   = OP_CLEAR;
								res_ok_d = 1'b0;
								state_d  = ST_RESP;
							end
						end
						FUNC_RANGE: begin
							any_d = 1'b0;
							if (range_ok) begin
								cmd.op   = OP_MARK_SET;
								res_ok_d = 1'b1;
								state_d  = ST_COMPACT;
							end else begin
								cmd.op   = OP_CLEAR;
								res_ok_d = 1'b0;
								state_d  = ST_RESP;
							end
						end
						FUNC_MARK: begin
							cmd.op = OP_MARK_ADD;
							if (set_last) begin
								res_ok_d = any_marked_q || a_ok;
								any_d    = 1'b0;
								state_d  = ST_COMPACT;
							end else begin
								res_ok_d = a_ok;
								any_d    = any_marked_q || a_ok;
								state_d  = ST_RESP;
							end
						end
						FUNC_LIST: begin
							any_d  = 1'b0;
							cmd.op = OP_CLEAR;
							if (count_q == '0) begin
								res_ok_d = 1'b1;
								state_d  = ST_RESP;
							end else begin
								idx_d   = '0;
								state_d = ST_LIST;
							end
						end
						default: begin
							res_ok_d = 1'b0;
							state_d  = ST_RESP;
						end
					endcase
				end
			end
			ST_COMPACT: begin
				if (mark_any) begin
					cmd.op = OP_STEP;
					if (hole_any) begin
						count_d = count_q - CW'(1);
					end
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (out_free) begin
					load    = 1'b1;
					ld_ok   = 1'b1;
					ld_has  = 1'b1;
					ld_last = list_last;
					cmd.op  = OP_ROTATE;
					idx_d   = idx_q + IW'(1);
					if (list_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			any_marked_q <= 1'b0;
			res_ok_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			idx_q        <= idx_d;
			any_marked_q <= any_d;
			res_ok_q     <= res_ok_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q          <= ld_ok;
			entry_count_q <= COUNT_W'(count_q);
			position_q    <= ld_has ? POS_W'(idx_q) : '0;
			entry_value_q <= ld_has ? dout_x[ENTRY_W-1:0] : '0;
			has_entry_q   <= ld_has;
			last_q        <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign entry_count = entry_count_q;
	assign position    = position_q;
	assign entry_value = entry_value_q;
	assign has_entry   = has_entry_q;
	assign last        = last_q;

endmodule

// File: hw/rtl/cls_checker.sv
module cls_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                ok,
	input logic [cls_pkg::COUNT_W-1:0]         entry_count,
	input logic [cls_pkg::POS_W-1:0]           position,
	input logic [cls_pkg::ENTRY_W-1:0]         entry_value,
	input logic                                has_entry,
	input logic                                last
);
	import cls_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(entry_count)
			&& $stable(position) && $stable(entry_value) && $stable(has_entry)
			&& $stable(last))
		else $error("stalled result word changed");

	a_list_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_entry |-> ok)
		else $error("listed entry without ok");

	// A word that carries no entry is the only result of its operation.
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_entry |-> last && position == '0 && entry_value == '0)
		else $error("non-list result malformed");

	// No new operation is taken while a listing is still being streamed.
	a_busy_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input accepted during a listing");

	a_list_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && has_entry && !last |=>
			!out_valid || (has_entry && position == $past(position) + POS_W'(1)))
		else $error("listed positions out of order");

endmodule

bind compacting_list_store cls_checker u_cls_checker (.*);
